/* rtl/core/crs_pkg.sv */
package crs_pkg;

    // Operation codes carried in the op field of an input item.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Width of the Horner accumulator and the coefficients.
    // The largest coefficient magnitude is below 2^35 and no step grows past 2^38.
    localparam int VAL_W = 40;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] param_t;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tan_x;
        logic signed [31:0] tan_y;
        logic signed [31:0] tan_z;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_READ,
        S_COEF,
        S_MUL,
        S_ACC,
        S_WB
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       clear;
        logic       append;
        logic       res_init;
        logic [1:0] res_status;
        logic       mod_start;
        logic       seg_open;
        logic       seg_loop;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       pt_we;
        logic [1:0] pt_sel;
        logic       coef;
        logic       mul;
        logic       acc;
        logic [2:0] step;
        logic [1:0] axis;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       lt2;
        logic       full;
        logic       loop_mode;
        logic       mod_done;
    } stat_t;

    // Halve with rounding to nearest, ties toward plus infinity.
    function automatic logic signed [VAL_W-1:0] half_round(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] s;
        begin
            s = v + VAL_W'(1);
            return s >>> 1;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] hi;
        logic signed [VAL_W-1:0] lo;
        begin
            hi = VAL_W'(33'sh0_7FFF_FFFF);
            lo = -VAL_W'(33'sh0_8000_0000);
            if (v > hi)
            begin
                return 32'sh7FFF_FFFF;
            end
            else if (v < lo)
            begin
                return 32'sh8000_0000;
            end
            return v[31:0];
        end
    endfunction

endpackage

/* rtl/core/catmull_rom_spline_eval.sv */
// Uniform Catmull-Rom evaluator over a store of up to MAX_POINTS 3D control points in
// signed fixed point with FRAC_BITS fractional bits. Every input transaction (clear,
// append, evaluate or the unused code) yields exactly one result transaction. The block
// works on one item at a time: it takes an item, finishes it into the output register,
// and then takes the next item while that result may still be waiting downstream.
// A clear or an append passes from decode straight to write-back, into the output
// register, and the block then returns to idle to take the next item. An evaluation
// goes through decode, reads four control points through the single read port of the
// point memory, runs the arithmetic (for each axis one coefficient step and five
// multiplies through one shared multiplier, each a multiply step followed by an
// accumulate step) and ends in write-back. The closed curve first runs the integer part
// of the parameter (16 bits at Q16.16) through an iterative modulo unit that retires one
// quotient bit per cycle. A result still stalled in the output register holds the block
// in write-back until it is taken. The point memory has no clearing pass; entries are
// only read below the fill count. loop_mode is written through the configuration
// channel, which is always ready, and must only be changed while the block is idle.
module catmull_rom_spline_eval #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  crs_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output crs_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import crs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The configuration register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    crs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    crs_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_item)
    );

endmodule

/* rtl/core/crs_mod.sv */
// Iterative floor modulo: one quotient bit per cycle, restoring remainder.
module crs_mod #(
    parameter int QW = 16,
    parameter int CW = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [QW-1:0] q,
    input  logic [CW-1:0]        segs,
    output logic                 done,
    output logic [CW-1:0]        res
);
    localparam int NW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [NW-1:0] cnt_reg;
    logic [QW-1:0] mag_reg;
    logic [CW-1:0] rem_reg;
    logic          neg_reg;
    logic [CW:0]   rem_wide;
    logic [CW-1:0] rem_next;

    always_comb
    begin
        rem_wide = {rem_reg, mag_reg[QW-1]};
        if (rem_wide >= {1'b0, segs})
        begin
            rem_next = CW'(rem_wide - {1'b0, segs});
        end
        else
        begin
            rem_next = CW'(rem_wide);
        end
    end

    // A negative dividend leaves a remainder that is folded back into [0, segs).
    assign res  = (neg_reg && rem_reg != '0) ? CW'(segs - rem_reg) : rem_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= q[QW-1] ? QW'(-q) : QW'(q);
            rem_reg <= '0;
            neg_reg <= q[QW-1];
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_reg << 1;
            rem_reg <= rem_next;
        end
    end

endmodule

/* rtl/core/crs_datapath.sv */
module crs_datapath #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  crs_pkg::in_item_t   in_item,
    input  logic                cfg_we,
    input  logic                cfg_data,
    input  crs_pkg::cmd_t       cmd,
    output crs_pkg::stat_t      stat,
    output crs_pkg::out_item_t  out_item
);
    import crs_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = CW + 1;
    localparam int QW = 32 - FRAC_BITS;
    localparam int LW = QW + CW;
    localparam int PW = VAL_W + FRAC_BITS + 1;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

    logic                    loop_reg;
    logic [CW-1:0]           count_reg;
    in_item_t                item_reg;
    logic [AW-1:0]           seg_reg;
    logic [FRAC_BITS-1:0]    u_reg;
    point_t                  mem [MAX_POINTS];
    point_t                  rdata_reg;
    point_t                  p_reg [4];
    logic signed [VAL_W-1:0] a_reg, b_reg, c_reg, d_reg, acc_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [31:0]      pos_reg [3];
    logic signed [31:0]      tan_reg [3];
    logic [1:0]              status_reg;
    out_item_t               out_reg;

    logic [CW-1:0]           segs;
    logic signed [QW-1:0]    q_s;
    logic [LW-1:0]           q_ext;
    logic [CW-1:0]           mod_res;
    logic                    mod_done;
    logic [IW-1:0]           n_w, s_w, s1_w, s2_w;
    logic [IW-1:0]           idx [4];
    logic [AW-1:0]           rd_addr;
    logic signed [VAL_W-1:0] pc [4];
    logic signed [VAL_W-1:0] a_c, b_c, c_c, d_c;
    logic signed [PW-1:0]    acc_ext, u_ext, prod_next, rnd_sum;
    logic signed [VAL_W-1:0] rprod, addend, v_sum;

    assign segs  = loop_reg ? count_reg : CW'(count_reg - CW'(1));
    assign q_s   = item_reg.param_t[31:FRAC_BITS];
    assign q_ext = LW'(unsigned'(q_s));

    crs_mod #(.QW(QW), .CW(CW)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mod_start),
        .q     (q_s),
        .segs  (segs),
        .done  (mod_done),
        .res   (mod_res)
    );

    assign stat.op        = item_reg.op;
    assign stat.lt2       = count_reg < CW'(2);
    assign stat.full      = count_reg >= CW'(MAX_POINTS);
    assign stat.loop_mode = loop_reg;
    assign stat.mod_done  = mod_done;

    // Neighbor indices seg-1 .. seg+2, wrapped in loop mode and clamped otherwise.
    always_comb
    begin
        n_w  = IW'(count_reg);
        s_w  = IW'(seg_reg);
        s1_w = s_w + IW'(1);
        s2_w = s_w + IW'(2);
        idx[1] = s_w;
        if (loop_reg)
        begin
            idx[0] = (s_w == '0) ? n_w - IW'(1) : s_w - IW'(1);
            idx[2] = (s1_w >= n_w) ? s1_w - n_w : s1_w;
            idx[3] = (s2_w >= n_w) ? s2_w - n_w : s2_w;
        end
        else
        begin
            idx[0] = (s_w == '0) ? '0 : s_w - IW'(1);
            idx[2] = s1_w;
            idx[3] = (s2_w > n_w - IW'(1)) ? n_w - IW'(1) : s2_w;
        end
        rd_addr = idx[cmd.rd_sel][AW-1:0];
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            unique case (cmd.axis)
                2'd1:    pc[k] = VAL_W'(p_reg[k].y);
                2'd2:    pc[k] = VAL_W'(p_reg[k].z);
                default: pc[k] = VAL_W'(p_reg[k].x);
            endcase
        end
        a_c = pc[1] <<< 1;
        b_c = pc[2] - pc[0];
        c_c = (pc[0] <<< 1) - ((pc[1] <<< 2) + pc[1]) + (pc[2] <<< 2) - pc[3];
        d_c = ((pc[1] <<< 1) + pc[1]) - pc[0] - ((pc[2] <<< 1) + pc[2]) + pc[3];
    end

    always_comb
    begin
        acc_ext   = PW'(acc_reg);
        u_ext     = PW'({1'b0, u_reg});
        prod_next = acc_ext * u_ext;
        rnd_sum   = prod_reg + HALF;
        rprod     = VAL_W'(rnd_sum >>> FRAC_BITS);
        unique case (cmd.step)
            3'd0:    addend = c_reg;
            3'd2:    addend = a_reg;
            3'd3:    addend = c_reg <<< 1;
            default: addend = b_reg;
        endcase
        v_sum = rprod + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                loop_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[count_reg[AW-1:0]] <= '{x: item_reg.point_x, y: item_reg.point_y,
                                         z: item_reg.point_z};
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            item_reg <= in_item;
        end
        if (cmd.seg_open)
        begin
            if (item_reg.param_t[31])
            begin
                seg_reg <= '0;
                u_reg   <= '0;
            end
            else if (q_ext >= LW'(segs))
            begin
                seg_reg <= AW'(segs - CW'(1));
                u_reg   <= '1;
            end
            else
            begin
                seg_reg <= AW'(q_ext);
                u_reg   <= item_reg.param_t[FRAC_BITS-1:0];
            end
        end
        else if (cmd.seg_loop)
        begin
            seg_reg <= AW'(mod_res);
            u_reg   <= item_reg.param_t[FRAC_BITS-1:0];
        end
        if (cmd.pt_we)
        begin
            p_reg[cmd.pt_sel] <= rdata_reg;
        end
        if (cmd.coef)
        begin
            a_reg   <= a_c;
            b_reg   <= b_c;
            c_reg   <= c_c;
            d_reg   <= d_c;
            acc_reg <= d_c;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.res_init)
        begin
            // An empty curve reports the unit tangent along Z.
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= '0;
                tan_reg[k] <= (k == 2 && cmd.res_status == STAT_EMPTY) ?
                              (32'sd1 <<< FRAC_BITS) : '0;
            end
            status_reg <= cmd.res_status;
        end
        if (cmd.acc)
        begin
            if (cmd.step == 3'd2)
            begin
                pos_reg[cmd.axis] <= sat32(half_round(v_sum));
                acc_reg           <= (d_reg <<< 1) + d_reg;
            end
            else if (cmd.step == 3'd4)
            begin
                tan_reg[cmd.axis] <= sat32(half_round(v_sum));
            end
            else
            begin
                acc_reg <= v_sum;
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= '{pos_x: pos_reg[0], pos_y: pos_reg[1], pos_z: pos_reg[2],
                         tan_x: tan_reg[0], tan_y: tan_reg[1], tan_z: tan_reg[2],
                         status: status_reg};
        end
    end

    assign out_item = out_reg;

endmodule

/* rtl/core/crs_ctrl.sv */
module crs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  crs_pkg::stat_t stat,
    output crs_pkg::cmd_t  cmd
);
    import crs_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] rd_cnt_reg;
    logic [2:0] step_reg;
    logic [1:0] axis_reg;
    logic       out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.op == OP_EVAL && !stat.lt2)
                begin
                    state_next = stat.loop_mode ? S_DIV : S_READ;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (rd_cnt_reg == 3'd4)
                begin
                    state_next = S_COEF;
                end
            end
            S_COEF:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (step_reg == 3'd4)
                begin
                    state_next = (axis_reg == 2'd2) ? S_WB : S_COEF;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_WB:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.step = step_reg;
        cmd.axis = axis_reg;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            S_DECODE:
            begin
                cmd.res_init   = 1'b1;
                cmd.res_status = STAT_OK;
                unique case (stat.op)
                    OP_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    OP_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = STAT_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                    end
                    OP_EVAL:
                    begin
                        if (stat.lt2)
                        begin
                            cmd.res_status = STAT_EMPTY;
                        end
                        else if (stat.loop_mode)
                        begin
                            cmd.mod_start = 1'b1;
                        end
                        else
                        begin
                            cmd.seg_open = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_status = STAT_OK;
                    end
                endcase
            end
            S_DIV:
            begin
                cmd.seg_loop = stat.mod_done;
            end
            S_READ:
            begin
                cmd.rd_en  = rd_cnt_reg != 3'd4;
                cmd.rd_sel = rd_cnt_reg[1:0];
                cmd.pt_we  = rd_cnt_reg != 3'd0;
                cmd.pt_sel = 2'(rd_cnt_reg - 3'd1);
            end
            S_COEF:
            begin
                cmd.coef = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
            end
            S_WB:
            begin
                cmd.out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            step_reg      <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_READ)
            begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
            end
            else
            begin
                rd_cnt_reg <= '0;
            end
            if (state_reg == S_ACC)
            begin
                step_reg <= (step_reg == 3'd4) ? 3'd0 : step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    axis_reg <= axis_reg + 2'd1;
                end
            end
            else if (state_reg == S_IDLE)
            begin
                step_reg <= '0;
                axis_reg <= '0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* dv/catmull_rom_spline_eval_tb.sv */
module catmull_rom_spline_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    // Depth of the point store and the fixed point format of the block.
    localparam int NPTS = 64;
    localparam int FRAC = 16;
    localparam longint ONE = longint'(1) << FRAC;
    // Cycles the block may still be busy after its last result, and the watchdog limit.
    localparam int SETTLE_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_ITEMS = 150;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    catmull_rom_spline_eval #(
        .MAX_POINTS(NPTS),
        .FRAC_BITS(FRAC)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // The clock runs at a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow of the block's state, kept by the predictor. The store holds the control
    // points in the order they were appended and the count tells how many are valid.
    point_t    shadow_pts[NPTS];
    int        shadow_count;
    logic      shadow_loop;

    // Results that the block still owes, oldest first.
    out_item_t spline_results_q[$];

    int  mismatches;
    bit  quiet;
    int  stall_pct;
    int  stall_left;
    int  idle_cycles;
    int  items_sent;

    // Divide by 2^s with rounding to nearest and ties toward plus infinity. An arithmetic
    // shift of a signed 64-bit value is a floor, which is what the rounding needs.
    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -longint'(64'sh8000_0000))
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Point index for neighbor i: wrapped modulo the count on a closed curve, clamped to
    // the ends on an open one.
    function automatic int nbr_index(longint i);
        longint r;
        if (shadow_loop)
        begin
            r = i % shadow_count;
            if (r < 0)
            begin
                r += shadow_count;
            end
            return int'(r);
        end
        if (i < 0)
        begin
            return 0;
        end
        if (i > shadow_count - 1)
        begin
            return shadow_count - 1;
        end
        return int'(i);
    endfunction

    // Horner evaluation of one coordinate: position and derivative for a segment.
    function automatic void cubic_axis(longint p0, longint p1, longint p2, longint p3,
                                       longint u, output logic signed [31:0] pos,
                                       output logic signed [31:0] tng);
        longint a;
        longint b;
        longint c;
        longint d;
        longint v;
        a = 2 * p1;
        b = p2 - p0;
        c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d = 3 * p1 - p0 - 3 * p2 + p3;
        v = rnd_shift(d * u, FRAC) + c;
        v = rnd_shift(v * u, FRAC) + b;
        v = rnd_shift(v * u, FRAC) + a;
        pos = clip32(rnd_shift(v, 1));
        v = rnd_shift(3 * d * u, FRAC) + 2 * c;
        v = rnd_shift(v * u, FRAC) + b;
        tng = clip32(rnd_shift(v, 1));
    endfunction

    // Works out the result of one input transaction and updates the shadow state.
    function automatic out_item_t predict_spline_out(in_item_t it);
        out_item_t r;
        longint segs;
        longint m;
        longint t;
        longint u;
        longint seg;
        point_t p[4];
        r = '0;
        r.status = STAT_OK;
        if (it.op == OP_CLEAR)
        begin
            shadow_count = 0;
        end
        else if (it.op == OP_APPEND)
        begin
            if (shadow_count >= NPTS)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                shadow_pts[shadow_count] = '{it.point_x, it.point_y, it.point_z};
                shadow_count++;
            end
        end
        else if (it.op == OP_EVAL)
        begin
            if (shadow_count < 2)
            begin
                r.tan_z = 32'(ONE);
                r.status = STAT_EMPTY;
            end
            else
            begin
                segs = shadow_loop ? shadow_count : shadow_count - 1;
                m = segs * ONE;
                t = longint'(it.param_t);
                if (shadow_loop)
                begin
                    t = t % m;
                    if (t < 0)
                    begin
                        t += m;
                    end
                end
                else
                begin
                    if (t < 0)
                    begin
                        t = 0;
                    end
                    if (t > m - 1)
                    begin
                        t = m - 1;
                    end
                end
                seg = t >>> FRAC;
                u = t & (ONE - 1);
                for (int k = 0; k < 4; k++)
                begin
                    p[k] = shadow_pts[nbr_index(seg - 1 + k)];
                end
                cubic_axis(p[0].x, p[1].x, p[2].x, p[3].x, u, r.pos_x, r.tan_x);
                cubic_axis(p[0].y, p[1].y, p[2].y, p[3].y, u, r.pos_y, r.tan_y);
                cubic_axis(p[0].z, p[1].z, p[2].z, p[3].z, u, r.pos_z, r.tan_z);
            end
        end
        return r;
    endfunction

    function automatic in_item_t mk_in(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z, logic [31:0] t);
        in_item_t it;
        it.op = op;
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        it.param_t = t;
        return it;
    endfunction

    function automatic out_item_t mk_out(logic [31:0] tz, logic [1:0] st);
        out_item_t r;
        r = '0;
        r.tan_z = tz;
        r.status = st;
        return r;
    endfunction

    // Hands one transaction to the block. Before it an idle gap of random length may
    // fall. The valid is only lowered inside such a gap, so it never drops and rises
    // again within one time step. When the expected result is known by inspection it
    // is queued in place of the predicted one, while the predictor still tracks state.
    task automatic send_item(in_item_t it, bit known, out_item_t known_res);
        out_item_t pred;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        pred = predict_spline_out(it);
        spline_results_q = {spline_results_q, (known ? known_res : pred)};
        in_valid <= 1'b1;
        in_item <= it;
        items_sent++;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Lowers the input valid and waits until every owed result has come, then lets the
    // block finish any trailing work that produces no result.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (spline_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes loop_mode through the configuration channel while the block is idle.
    task automatic set_loop_mode(logic mode);
        drain_block();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        shadow_loop = mode;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Coordinates mix full range words, the two extremes and modest values so that both
    // the saturation paths and ordinary curves are reached.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        endcase
    endfunction

    // Parameters mostly fall within n + 2 segments either side of zero, past both ends of
    // the curve, with some full range words to exercise the wrap and the clamp far out.
    function automatic logic [31:0] rand_param(int n);
        longint span;
        span = longint'(n + 2) * ONE;
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        return 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    // One well-formed sequence: usually a clear, a run of appends (sometimes past the
    // store's capacity) and a burst of evaluations. At times one noise item instead.
    task automatic send_sequence();
        int n;
        int e;
        if ($urandom_range(0, 9) == 0)
        begin
            send_item(mk_in(2'($urandom), $urandom, $urandom, $urandom, $urandom), 0, '0);
            return;
        end
        if ($urandom_range(0, 5) != 0)
        begin
            send_item(mk_in(OP_CLEAR, $urandom, $urandom, $urandom, $urandom), 0, '0);
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(62, 68) : $urandom_range(0, 9);
        for (int k = 0; k < n; k++)
        begin
            send_item(mk_in(OP_APPEND, rand_coord(), rand_coord(), rand_coord(), $urandom),
                      0, '0);
        end
        e = $urandom_range(2, 10);
        for (int k = 0; k < e; k++)
        begin
            send_item(mk_in(OP_EVAL, $urandom, $urandom, $urandom,
                            rand_param(shadow_count)), 0, '0);
        end
    endtask

    // Output side: results are checked in order as they are accepted.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (spline_results_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result transaction %h", out_item);
                end
            end
            else
            begin
                want = spline_results_q.pop_front();
                if (out_item.pos_x !== want.pos_x || out_item.pos_y !== want.pos_y ||
                    out_item.pos_z !== want.pos_z || out_item.tan_x !== want.tan_x ||
                    out_item.tan_y !== want.tan_y || out_item.tan_z !== want.tan_z ||
                    out_item.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result mismatch: expected pos %h %h %h tan %h %h %h st %0d",
                                 want.pos_x, want.pos_y, want.pos_z,
                                 want.tan_x, want.tan_y, want.tan_z, want.status);
                        $display("                 actual   pos %h %h %h tan %h %h %h st %0d",
                                 out_item.pos_x, out_item.pos_y, out_item.pos_z,
                                 out_item.tan_x, out_item.tan_y, out_item.tan_z,
                                 out_item.status);
                    end
                end
            end
        end
    end

    // Receiver back-pressure comes in bursts whose frequency changes from phase to phase;
    // a zero rate gives long stretches with no stall at all.
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: counts cycles in which no transaction moves on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        mismatches = 0;
        quiet = 0;
        stall_pct = 10;
        stall_left = 0;
        idle_cycles = 0;
        items_sent = 0;
        shadow_count = 0;
        shadow_loop = 1'b0;
        for (int k = 0; k < NPTS; k++)
        begin
            shadow_pts[k] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on an open curve. Rows with an obvious answer carry it: an
        // evaluation with fewer than two points, clears, accepted appends and the unused
        // opcode. The rest go through the predictor: a two point curve with opposite
        // extreme coordinates, parameters at both word extremes, and segment interiors.
        set_loop_mode(1'b0);
        send_item(mk_in(OP_EVAL, 0, 0, 0, 32'h0001_0000), 1, mk_out(32'h0001_0000, STAT_EMPTY));
        send_item(mk_in(2'd3, '1, '1, '1, '1), 1, mk_out(0, STAT_OK));
        send_item(mk_in(OP_CLEAR, '1, '1, '1, '1), 1, mk_out(0, STAT_OK));
        send_item(mk_in(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 0, '1), 1, mk_out(0, STAT_OK));
        send_item(mk_in(OP_EVAL, '1, '1, '1, 0), 1, mk_out(32'h0001_0000, STAT_EMPTY));
        send_item(mk_in(OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, '1, 0), 1, mk_out(0, STAT_OK));
        send_item(mk_in(OP_EVAL, 0, 0, 0, 0), 0, '0);
        send_item(mk_in(OP_EVAL, 0, 0, 0, 32'h8000_0000), 0, '0);
        send_item(mk_in(OP_EVAL, 0, 0, 0, 32'h7FFF_FFFF), 0, '0);
        send_item(mk_in(OP_EVAL, 0, 0, 0, 32'h0000_8000), 0, '0);
        send_item(mk_in(OP_APPEND, 32'h0001_0000, 32'h1234_5678, 32'hFFFE_0000, 0), 1,
                  mk_out(0, STAT_OK));
        send_item(mk_in(OP_APPEND, 32'h0003_0000, 32'hEDCB_A988, 32'h0002_0000, 0), 1,
                  mk_out(0, STAT_OK));
        send_item(mk_in(OP_EVAL, 0, 0, 0, 32'h0001_8000), 0, '0);
        send_item(mk_in(OP_EVAL, 0, 0, 0, 32'h0002_FFFF), 0, '0);
        send_item(mk_in(OP_EVAL, 0, 0, 0, 32'hFFFF_FFFF), 0, '0);
        send_item(mk_in(OP_CLEAR, 0, 0, 0, 0), 1, mk_out(0, STAT_OK));
        send_item(mk_in(OP_EVAL, 0, 0, 0, 32'h0000_4000), 1, mk_out(32'h0001_0000, STAT_EMPTY));

        // Random part in phases that alternate between open and closed curves. The last
        // stretch runs with no idling on either side.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_loop_mode(ph % 2 == 0);
            stall_pct = (ph == 2) ? 0 : 5 + 10 * (ph % 3);
            while (items_sent < 17 + (ph + 1) * (RANDOM_ITEMS - QUIET_ITEMS) / 6)
            begin
                send_sequence();
            end
        end
        set_loop_mode(1'b1);
        quiet = 1;
        while (items_sent < 17 + RANDOM_ITEMS)
        begin
            send_sequence();
        end
        drain_block();

        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* catmull_rom_spline_eval.f */
rtl/core/crs_pkg.sv
rtl/core/crs_mod.sv
rtl/core/crs_datapath.sv
rtl/core/crs_ctrl.sv
rtl/core/catmull_rom_spline_eval.sv
dv/catmull_rom_spline_eval_tb.sv
